/* src/segment_reorder_window_assert.svh */
// assertion macros used by the reorder window datapath
// no dependencies; included by sro_datapath, the one file that asserts
`ifndef SEGMENT_REORDER_WINDOW_ASSERT_SVH
`define SEGMENT_REORDER_WINDOW_ASSERT_SVH

// same-cycle implication, masked during reset
`define SRO_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reorder window check failed");

// next-cycle implication, masked during reset
`define SRO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reorder window check failed");

`endif

/* src/sro_pkg.sv */
// shared types and codes of the segment reorder window
// no dependencies
package sro_pkg;

  localparam int MAX_RELEASES = 8;
  localparam int CNT_W        = $clog2(MAX_RELEASES);

  localparam logic [2:0] STAT_ACCEPTED  = 3'd0;
  localparam logic [2:0] STAT_ZERO_LEN  = 3'd1;
  localparam logic [2:0] STAT_OUTSIDE   = 3'd2;
  localparam logic [2:0] STAT_DUPLICATE = 3'd3;
  localparam logic [2:0] STAT_OVER_CAP  = 3'd4;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [19:0] CAPACITY_RESET = 20'd4096;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic release_seg;
    logic at_limit;
  } sro_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic head_valid;
    logic head_written;
    logic next_valid;
  } sro_flags_t;

endpackage

/* src/sro_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module sro_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/sro_ctrl.sv */
// sequencing controller of the segment reorder window
// depends on sro_pkg
module sro_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sro_pkg::sro_flags_t flags,
  output sro_pkg::sro_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [sro_pkg::CNT_W-1:0] cnt;
  logic [sro_pkg::CNT_W-1:0] cnt_next;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    cmd.capture     = 1'b0;
    cmd.check       = 1'b0;
    cmd.release_seg = 1'b0;
    cmd.at_limit    = (cnt == sro_pkg::CNT_W'(sro_pkg::MAX_RELEASES - 1));
    in_stall        = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (flags.out_free) begin
          cmd.check = 1'b1;
          cnt_next  = '0;
          if (!flags.head_valid) begin
            state_next = ST_IDLE;
          end else if (flags.head_written) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (flags.out_free) begin
          cmd.release_seg = 1'b1;
          cnt_next        = cnt + 1'b1;
          if (cmd.at_limit || !flags.next_valid) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

/* src/sro_datapath.sv */
// window state, slot store and result register of the segment reorder window
// depends on sro_pkg, sro_ram and the assertion header
`include "segment_reorder_window_assert.svh"

module sro_datapath #(
  parameter int WINDOW_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [19:0]         cfg_data,
  input  logic [15:0]         seqno,
  input  logic [15:0]         segment_length,
  input  logic [31:0]         payload_handle,
  input  sro_pkg::sro_cmd_t   cmd,
  output sro_pkg::sro_flags_t flags,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic [2:0]          status,
  output logic [15:0]         accepted_length,
  output logic [31:0]         released_handle,
  output logic [15:0]         released_length,
  output logic [15:0]         released_seqno,
  output logic [15:0]         expected_seqno,
  output logic [19:0]         pending_bytes,
  output logic                last
);

  localparam int SLOT_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  // captured input
  logic [15:0] seq_q;
  logic [15:0] len_q;
  logic [31:0] handle_q;

  // window state
  logic [WINDOW_SLOTS-1:0] slot_valid;
  logic [15:0]             next_expected;
  logic [19:0]             bytes_held;
  logic [SLOT_W-1:0]       window_base;
  logic [19:0]             capacity;

  logic [15:0]             offset;
  logic                    in_window;
  logic [SLOT_W:0]         slot_sum;
  logic [SLOT_W-1:0]       slot;
  logic [20:0]             held_sum;
  logic [2:0]              verdict;
  logic                    ok;
  logic [WINDOW_SLOTS-1:0] slot_mask;
  logic [WINDOW_SLOTS-1:0] base_mask;
  logic [WINDOW_SLOTS-1:0] valid_stored;
  logic [WINDOW_SLOTS-1:0] valid_cleared;
  logic [SLOT_W-1:0]       base_inc;
  logic [15:0]             expected_inc;
  logic [19:0]             bytes_stored;
  logic [19:0]             bytes_released;
  logic [47:0]             ram_rdata;
  logic [SLOT_W-1:0]       ram_raddr;
  logic                    ram_we;

  always_comb begin
    offset    = seq_q - next_expected;
    in_window = offset < 16'(WINDOW_SLOTS);
    slot_sum  = {1'b0, window_base} + {1'b0, offset[SLOT_W-1:0]};
    if (slot_sum >= (SLOT_W + 1)'(WINDOW_SLOTS)) begin
      slot = SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW_SLOTS));
    end else begin
      slot = slot_sum[SLOT_W-1:0];
    end
    held_sum = {1'b0, bytes_held} + {5'd0, len_q};
    priority if (len_q == 16'd0) begin
      verdict = sro_pkg::STAT_ZERO_LEN;
    end else if (!in_window) begin
      verdict = sro_pkg::STAT_OUTSIDE;
    end else if (slot_valid[slot]) begin
      verdict = sro_pkg::STAT_DUPLICATE;
    end else if (held_sum > {1'b0, capacity}) begin
      verdict = sro_pkg::STAT_OVER_CAP;
    end else begin
      verdict = sro_pkg::STAT_ACCEPTED;
    end
    ok            = (verdict == sro_pkg::STAT_ACCEPTED);
    slot_mask     = WINDOW_SLOTS'(1) << slot;
    base_mask     = WINDOW_SLOTS'(1) << window_base;
    valid_stored  = ok ? (slot_valid | slot_mask) : slot_valid;
    valid_cleared = slot_valid & ~base_mask;
    base_inc      = (window_base == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : window_base + 1'b1;
    expected_inc  = next_expected + 16'd1;
    bytes_stored  = ok ? held_sum[19:0] : bytes_held;
    bytes_released = bytes_held - {4'd0, ram_rdata[15:0]};
  end

  assign flags.out_free     = !out_valid || !out_stall;
  assign flags.head_valid   = valid_stored[window_base];
  assign flags.head_written = ok && (slot == window_base);
  assign flags.next_valid   = valid_cleared[base_inc];

  // read the head now, or the slot after it while a release goes out
  assign ram_raddr = cmd.release_seg ? base_inc : window_base;
  assign ram_we    = cmd.check && ok;

  sro_ram #(
    .WIDTH(48),
    .DEPTH(WINDOW_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata({handle_q, len_q}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      seq_q    <= seqno;
      len_q    <= segment_length;
      handle_q <= payload_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      next_expected <= '0;
      bytes_held    <= '0;
      window_base   <= '0;
      capacity      <= sro_pkg::CAPACITY_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
      if (cmd.check) begin
        slot_valid <= valid_stored;
        bytes_held <= bytes_stored;
      end else if (cmd.release_seg) begin
        slot_valid    <= valid_cleared;
        bytes_held    <= bytes_released;
        next_expected <= expected_inc;
        window_base   <= base_inc;
      end
      if (cmd.check || cmd.release_seg) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register, loaded only when the previous result has gone
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      kind            <= sro_pkg::KIND_VERDICT;
      status          <= verdict;
      accepted_length <= ok ? len_q : 16'd0;
      released_handle <= '0;
      released_length <= '0;
      released_seqno  <= '0;
      expected_seqno  <= next_expected;
      pending_bytes   <= bytes_stored;
      last            <= !valid_stored[window_base];
    end else if (cmd.release_seg) begin
      kind            <= sro_pkg::KIND_RELEASE;
      status          <= sro_pkg::STAT_ACCEPTED;
      accepted_length <= '0;
      released_handle <= ram_rdata[47:16];
      released_length <= ram_rdata[15:0];
      released_seqno  <= next_expected;
      expected_seqno  <= expected_inc;
      pending_bytes   <= bytes_released;
      last            <= cmd.at_limit || !valid_cleared[base_inc];
    end
  end

  `SRO_ASSERT_NOW(a_release_head_valid, clk, rst, cmd.release_seg, slot_valid[window_base])
  `SRO_ASSERT_NEXT(a_check_gives_verdict, clk, rst, cmd.check,
                   out_valid && (kind == sro_pkg::KIND_VERDICT))
  `SRO_ASSERT_NEXT(a_release_advances, clk, rst, cmd.release_seg,
                   out_valid && (kind == sro_pkg::KIND_RELEASE) &&
                   (released_seqno == $past(next_expected)))

endmodule

/* src/segment_reorder_window.sv */
// top level of the segment reorder window: controller, datapath, config port
// depends on sro_pkg, sro_ctrl, sro_datapath (and through it sro_ram)
//
// usage
//   input channel (in_valid / in_stall): one segment descriptor per transfer,
//   seqno, segment_length and payload_handle. a transfer happens only while
//   the block is idle; in_stall stays high while an item is being worked on
//   output channel (out_valid / out_stall): each input gives one verdict
//   (kind 0) followed by up to eight releases (kind 1) of in-order segments,
//   the final one flagged by last. a stalled result holds its fields
//   config channel (cfg_valid / cfg_ready / cfg_data): writes capacity; it is
//   always ready and should only be used while no item is in flight
//   sequence: the input is captured, then the check state gives the verdict;
//   each release comes from the drain state, the first after a fetch state when
//   the new segment lands in the head slot (slot ram registered read). a
//   stall holds check and drain; the next item is taken back in idle
//   reset: all slots empty, expected number and pending bytes zero, capacity
//   4096; no clearing pass is needed
//   a stalled receiver simply freezes the sequence; nothing is dropped
module segment_reorder_window #(
  parameter int WINDOW_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data,
  // input segments
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] seqno,
  input  logic [15:0] segment_length,
  input  logic [31:0] payload_handle,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [2:0]  status,
  output logic [15:0] accepted_length,
  output logic [31:0] released_handle,
  output logic [15:0] released_length,
  output logic [15:0] released_seqno,
  output logic [15:0] expected_seqno,
  output logic [19:0] pending_bytes,
  output logic        last
);

  sro_pkg::sro_cmd_t   cmd;
  sro_pkg::sro_flags_t flags;

  // capacity register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // state machine: idle, check, optional fetch, drain
  sro_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .flags   (flags),
    .cmd     (cmd)
  );

  // window bookkeeping, slot ram and result register
  sro_datapath #(
    .WINDOW_SLOTS(WINDOW_SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .seqno          (seqno),
    .segment_length (segment_length),
    .payload_handle (payload_handle),
    .cmd            (cmd),
    .flags          (flags),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .status         (status),
    .accepted_length(accepted_length),
    .released_handle(released_handle),
    .released_length(released_length),
    .released_seqno (released_seqno),
    .expected_seqno (expected_seqno),
    .pending_bytes  (pending_bytes),
    .last           (last)
  );

endmodule

/* test/segment_reorder_window_tb.sv */
// self-checking testbench for the segment reorder window
// depends on sro_pkg and segment_reorder_window
// an in-bench mirror of the window predicts every result
module segment_reorder_window_tb;

  localparam int SLOTS = 8;

  // one result as seen on the output channel
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [15:0] acc_len;
    logic [31:0] handle;
    logic [15:0] rel_len;
    logic [15:0] rel_seq;
    logic [15:0] exp_seq;
    logic [19:0] pend;
    logic        last;
  } seg_result_t;

  // mirror of the reorder window: slot contents, expected number, held bytes,
  // capacity, and the queue of results still owed by the block
  class reorder_window_mirror;
    bit          slot_full   [SLOTS];
    logic [31:0] slot_handle [SLOTS];
    logic [15:0] slot_len    [SLOTS];
    logic [15:0] next_exp;
    logic [19:0] held;
    int          base;
    logic [19:0] capacity;
    seg_result_t due_results [$];
    int          fault_count;

    function new();
      foreach (slot_full[i]) slot_full[i] = 1'b0;
      next_exp    = '0;
      held        = '0;
      base        = 0;
      capacity    = sro_pkg::CAPACITY_RESET;
      fault_count = 0;
    endfunction

    // work out the verdict and any releases that follow for one segment taken in
    function void note_segment(logic [15:0] seq, logic [15:0] len, logic [31:0] hdl);
      logic [15:0] offset;
      logic [2:0]  verdict;
      int          slot;
      int          drained;
      seg_result_t r;
      offset  = seq - next_exp;
      slot    = 0;
      verdict = sro_pkg::STAT_ACCEPTED;
      if (len == 16'd0) begin
        verdict = sro_pkg::STAT_ZERO_LEN;
      end else if (offset >= 16'(SLOTS)) begin
        verdict = sro_pkg::STAT_OUTSIDE;
      end else begin
        slot = (base + int'(offset)) % SLOTS;
        if (slot_full[slot]) begin
          verdict = sro_pkg::STAT_DUPLICATE;
        end else if (({12'b0, held} + {16'b0, len}) > {12'b0, capacity}) begin
          verdict = sro_pkg::STAT_OVER_CAP;
        end
      end
      if (verdict == sro_pkg::STAT_ACCEPTED) begin
        slot_full[slot]   = 1'b1;
        slot_handle[slot] = hdl;
        slot_len[slot]    = len;
        held              = held + {4'b0, len};
      end
      r         = '0;
      r.kind    = sro_pkg::KIND_VERDICT;
      r.status  = verdict;
      r.acc_len = (verdict == sro_pkg::STAT_ACCEPTED) ? len : 16'd0;
      r.exp_seq = next_exp;
      r.pend    = held;
      due_results.push_back(r);
      drained = 0;
      while (drained < sro_pkg::MAX_RELEASES && slot_full[base]) begin
        slot_full[base] = 1'b0;
        held            = held - {4'b0, slot_len[base]};
        r               = '0;
        r.kind          = sro_pkg::KIND_RELEASE;
        r.handle        = slot_handle[base];
        r.rel_len       = slot_len[base];
        r.rel_seq       = next_exp;
        next_exp        = next_exp + 16'd1;
        base            = (base + 1) % SLOTS;
        r.exp_seq       = next_exp;
        r.pend          = held;
        due_results.push_back(r);
        drained++;
      end
      due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function string show(seg_result_t r);
      return $sformatf({"kind=%0d st=%0d acc=%0d hdl=%h len=%0d seq=%0d",
                        " exp=%0d pend=%0d last=%0d"},
                       r.kind, r.status, r.acc_len, r.handle, r.rel_len, r.rel_seq,
                       r.exp_seq, r.pend, r.last);
    endfunction

    task report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      fault_count++;
    endtask

    // compare one output transfer with the oldest owed result
    task check_result(seg_result_t got);
      seg_result_t want;
      string       diffs;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %s", show(got)));
        return;
      end
      want  = due_results.pop_front();
      diffs = "";
      if (got.kind    !== want.kind)    diffs = {diffs, " kind"};
      if (got.status  !== want.status)  diffs = {diffs, " status"};
      if (got.acc_len !== want.acc_len) diffs = {diffs, " accepted_length"};
      if (got.handle  !== want.handle)  diffs = {diffs, " released_handle"};
      if (got.rel_len !== want.rel_len) diffs = {diffs, " released_length"};
      if (got.rel_seq !== want.rel_seq) diffs = {diffs, " released_seqno"};
      if (got.exp_seq !== want.exp_seq) diffs = {diffs, " expected_seqno"};
      if (got.pend    !== want.pend)    diffs = {diffs, " pending_bytes"};
      if (got.last    !== want.last)    diffs = {diffs, " last"};
      if (diffs != "") begin
        report_mismatch($sformatf("[%s ] got %s, wanted %s", diffs, show(got), show(want)));
      end
    endtask
  endclass

  // clock, reset and block ports; every input starts at a known value
  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [19:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [15:0] seqno          = '0;
  logic [15:0] segment_length = '0;
  logic [31:0] payload_handle = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        kind;
  logic [2:0]  status;
  logic [15:0] accepted_length;
  logic [31:0] released_handle;
  logic [15:0] released_length;
  logic [15:0] released_seqno;
  logic [15:0] expected_seqno;
  logic [19:0] pending_bytes;
  logic        last;

  // idling in percent of cycles, changed per phase
  int send_idle_pct = 0;
  int stall_pct     = 0;

  reorder_window_mirror mirror;
  seg_result_t          seen;

  segment_reorder_window #(
    .WINDOW_SLOTS(SLOTS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .seqno          (seqno),
    .segment_length (segment_length),
    .payload_handle (payload_handle),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .status         (status),
    .accepted_length(accepted_length),
    .released_handle(released_handle),
    .released_length(released_length),
    .released_seqno (released_seqno),
    .expected_seqno (expected_seqno),
    .pending_bytes  (pending_bytes),
    .last           (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: stall drawn afresh every cycle, independent of out_valid
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // output monitor: sampled at the edge, so values are the pre-edge ones
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = '{kind, status, accepted_length, released_handle, released_length,
               released_seqno, expected_seqno, pending_bytes, last};
      mirror.check_result(seen);
    end
  end

  // offer one segment and wait for its transfer; valid is left high on return
  // so that a back-to-back segment needs no second assignment in the same step
  task automatic send_segment(logic [15:0] seq, logic [15:0] len, logic [31:0] hdl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    seqno          <= seq;
    segment_length <= len;
    payload_handle <= hdl;
    do @(posedge clk); while (in_stall);
    mirror.note_segment(seq, len, hdl);
  endtask

  // drop valid, wait until every owed result has arrived, then let the block go quiet
  task automatic settle(int quiet_cycles);
    in_valid <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk);
    repeat (quiet_cycles) @(posedge clk);
  endtask

  // capacity is only written with nothing in flight
  task automatic write_capacity(logic [19:0] value);
    settle(4);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    mirror.capacity = value;
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed segments inside the window, with the head favoured so
  // that drains happen; the rest is zero length, stale, far-off or huge
  task automatic send_random();
    logic [15:0] seq;
    logic [15:0] len;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      len = '0;
    end else if (pick < 14) begin
      len = 16'($urandom());
    end else begin
      len = 16'($urandom_range(1, 400));
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      seq = 16'($urandom());
    end else if (pick < 10) begin
      seq = mirror.next_exp + 16'($urandom_range(SLOTS, SLOTS + 8));
    end else if (pick < 14) begin
      seq = mirror.next_exp - 16'($urandom_range(1, 8));
    end else if (pick < 34) begin
      seq = mirror.next_exp;
    end else begin
      seq = mirror.next_exp + 16'($urandom_range(1, SLOTS - 1));
    end
    send_segment(seq, len, $urandom());
  endtask

  initial begin
    logic [19:0] phase_cap [4];
    int          phase_send_idle [4];
    int          phase_stall [4];
    phase_cap       = '{20'hFFFFF, 20'd900, 20'd0, 20'd2500};
    phase_send_idle = '{0, 60, 0, 38};
    phase_stall     = '{0, 0, 60, 38};
    phase_cap[2]    = 20'($urandom_range(1, 20'hFFFFF));
    mirror = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, at the reset capacity
    send_segment(16'd0,     16'd0,     32'hFFFF_FFFF); // zero length
    send_segment(16'd8,     16'd10,    32'h0000_0001); // just past the window
    send_segment(16'hFFFF,  16'd10,    32'h0000_0002); // behind the window
    send_segment(16'd3,     16'd100,   32'h0000_0000); // stored out of order
    send_segment(16'd3,     16'd5,     32'h1234_5678); // slot already taken
    send_segment(16'd1,     16'hFFFF,  32'h8765_4321); // over capacity
    send_segment(16'd7,     16'd3995,  32'hDEAD_BEEF); // held one short of capacity
    send_segment(16'd5,     16'd2,     32'h0BAD_F00D); // one byte too many
    send_segment(16'd0,     16'd1,     32'hFFFF_FFFF); // fills capacity exactly, drains head

    // full window drained by a single head arrival: eight releases
    write_capacity(20'hFFFFF);
    send_segment(16'd2,     16'hFFFF,  32'hA5A5_A5A5);
    send_segment(16'd4,     16'hFFFF,  32'h5A5A_5A5A);
    send_segment(16'd5,     16'h8000,  32'hC3C3_C3C3);
    send_segment(16'd6,     16'd1,     32'h3C3C_3C3C);
    send_segment(16'd8,     16'h7FFF,  32'hF0F0_0F0F);
    send_segment(16'd1,     16'd1,     32'h0F0F_F0F0);

    // capacity dropped below held bytes, then to zero, then restored
    send_segment(16'd10,    16'd500,   32'h1111_2222);
    write_capacity(20'd1);
    send_segment(16'd11,    16'd1,     32'h3333_4444);
    send_segment(16'd9,     16'd1,     32'h5555_6666);
    write_capacity(20'd0);
    send_segment(16'd12,    16'd1,     32'h7777_8888);
    write_capacity(sro_pkg::CAPACITY_RESET);
    send_segment(16'd9,     16'd1,     32'hFFFF_FFFF);

    // random phases, each at its own capacity and idling mix
    for (int ph = 0; ph < 4; ph++) begin
      write_capacity(phase_cap[ph]);
      send_idle_pct = phase_send_idle[ph];
      stall_pct     = phase_stall[ph];
      repeat (83) send_random();
    end

    settle(20);
    if (mirror.fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
